FILE: hw/rtl/kpu_pkg.sv
package kpu_pkg;

  localparam int unsigned MAX_POOL = 16;
  localparam int unsigned RANK_W   = 45;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned ELEM_W   = 4;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned QBIT_W   = 2;
  // Shifted divisor needs room for three extra bits plus a guard bit.
  localparam int unsigned WIDE_W   = RANK_W + ELEM_W;

  typedef enum logic [0:0] {
    REG_POOL_SIZE   = 1'b0,
    REG_DRAW_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_CHK  = 6'b000100,
    S_DIV  = 6'b001000,
    S_EMIT = 6'b010000,
    S_ERR  = 6'b100000
  } state_t;

endpackage

FILE: hw/rtl/kpu_if.sv
interface kpu_in_if (input logic clk);
  logic                       valid;
  logic                       ready;
  logic [kpu_pkg::RANK_W-1:0] ordinal_rank;
  modport source (output valid, output ordinal_rank, input ready);
  modport sink   (input valid, input ordinal_rank, output ready);
endinterface

interface kpu_out_if (input logic clk);
  logic                       valid;
  logic                       ready;
  logic [kpu_pkg::ELEM_W-1:0] element;
  logic [kpu_pkg::POS_W-1:0]  position;
  logic                       last_of_draw;
  logic                       error;
  modport source (output valid, output element, output position, output last_of_draw,
                  output error, input ready);
  modport sink   (input valid, input element, input position, input last_of_draw,
                  input error, output ready);
endinterface

FILE: hw/rtl/kpu_elem_cell.sv
module kpu_elem_cell (
  input  logic                       clk,
  input  logic                       init,
  input  logic [kpu_pkg::ELEM_W-1:0] init_val,
  input  logic                       shift,
  input  logic [kpu_pkg::ELEM_W-1:0] next_val,
  output logic [kpu_pkg::ELEM_W-1:0] value
);
  import kpu_pkg::*;

  logic [ELEM_W-1:0] value_r;

  // One entry of the ascending list of unused elements. Removing an entry
  // pulls every later entry one place toward the head.
  always_ff @(posedge clk) begin
    if (init) begin
      value_r <= init_val;
    end else if (shift) begin
      value_r <= next_val;
    end
  end

  assign value = value_r;

endmodule

FILE: hw/rtl/k_permutation_unrank.sv
// k-permutation unranking.
// Configure pool_size (index 0) and draw_length (index 1) through the cfg
// write port while the block is idle; both reset to 1.
// Each word accepted on in_ch carries a zero based rank. The block answers
// with draw_length words on out_ch, one element per position, position
// counting from 0 and last_of_draw set on the final word. A rank at or above
// the falling factorial, a draw_length of 0, a draw_length above pool_size,
// or a pool_size above 16 gives one word with error and last_of_draw set instead.
// The multiply steps build the falling factorial and the per-position
// divisors, a check step tests the rank, then each position takes a four-bit
// quotient from compare-subtract steps on the shared quotient unit and an emit
// step; a draw is finished before the next word is accepted (in_ch.ready is
// high only when idle).
// The result sits in an output register; a stalled receiver holds that word
// and the block waits in its emit step until the register frees up.
// Reset clears the sequencer and the output valid and restores the registers.
module k_permutation_unrank (
  input  logic                       clk,
  input  logic                       rst_n,
  kpu_in_if.sink                     in_ch,
  kpu_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [kpu_pkg::CFG_W-1:0]  cfg_data
);
  import kpu_pkg::*;

  state_t              state_r;
  logic [CFG_W-1:0]    pool_r, draw_r, n_r, k_r;
  logic [POS_W-1:0]    j_r, pos_r, q_r;
  logic [QBIT_W-1:0]   bit_r;
  logic [RANK_W-1:0]   rank_r, acc_r;
  logic [RANK_W-1:0]   stk_r [MAX_POOL];
  logic                out_valid_r, out_last_r, out_err_r;
  logic [ELEM_W-1:0]   out_elem_r;
  logic [POS_W-1:0]    out_pos_r;

  logic                in_fire, out_free, emit_fire, cfg_bad;
  logic [CFG_W-1:0]    factor;
  logic [RANK_W+CFG_W-1:0] prod;
  logic [WIDE_W-1:0]   shifted;
  logic                fits;
  logic [ELEM_W-1:0]   vals [MAX_POOL];
  logic [ELEM_W-1:0]   pick;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign emit_fire   = (state_r == S_EMIT) && out_free;
  assign cfg_bad     = (draw_r == '0) || (draw_r > pool_r) || (pool_r > CFG_W'(MAX_POOL));

  assign factor  = n_r - {1'b0, j_r};
  assign prod    = acc_r * factor;
  assign shifted = {{ELEM_W{1'b0}}, stk_r[0]} << bit_r;
  assign fits    = {{ELEM_W{1'b0}}, rank_r} >= shifted;
  assign pick    = vals[q_r];

  genvar gi;
  generate
    for (gi = 0; gi < MAX_POOL; gi++) begin : g_cell
      logic [ELEM_W-1:0] nb;
      if (gi == MAX_POOL - 1) begin : g_end
        assign nb = '0;
      end else begin : g_mid
        assign nb = vals[gi+1];
      end
      kpu_elem_cell u_cell (
        .clk      (clk),
        .init     (in_fire),
        .init_val (ELEM_W'(gi)),
        .shift    (emit_fire && (POS_W'(gi) >= q_r)),
        .next_val (nb),
        .value    (vals[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= CFG_W'(1);
      draw_r <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POOL_SIZE:   pool_r <= cfg_data;
        REG_DRAW_LENGTH: draw_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Divisor stack: during the multiply phase the divisors are pushed from the
  // last position back to the first, so position order pops them off the head.
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      stk_r[0] <= acc_r;
      for (int i = 1; i < MAX_POOL; i++) stk_r[i] <= stk_r[i-1];
    end else if (emit_fire) begin
      for (int i = 0; i < MAX_POOL - 1; i++) stk_r[i] <= stk_r[i+1];
      stk_r[MAX_POOL-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          rank_r  <= in_ch.ordinal_rank;
          n_r     <= pool_r;
          k_r     <= draw_r;
          j_r     <= POS_W'(draw_r - CFG_W'(1));
          acc_r   <= RANK_W'(1);
          pos_r   <= '0;
          state_r <= cfg_bad ? S_ERR : S_MUL;
        end
        S_MUL: begin
          acc_r <= prod[RANK_W-1:0];
          j_r   <= j_r - POS_W'(1);
          if (j_r == '0) state_r <= S_CHK;
        end
        S_CHK: begin
          bit_r   <= '1;
          q_r     <= '0;
          state_r <= (rank_r >= acc_r) ? S_ERR : S_DIV;
        end
        S_DIV: begin
          if (fits) begin
            rank_r     <= rank_r - shifted[RANK_W-1:0];
            q_r[bit_r] <= 1'b1;
          end
          bit_r <= bit_r - QBIT_W'(1);
          if (bit_r == '0) state_r <= S_EMIT;
        end
        S_EMIT: if (out_free) begin
          pos_r <= pos_r + POS_W'(1);
          bit_r <= '1;
          q_r   <= '0;
          state_r <= ({1'b0, pos_r} == k_r - CFG_W'(1)) ? S_IDLE : S_DIV;
        end
        S_ERR: if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire || ((state_r == S_ERR) && out_free)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_elem_r <= pick;
      out_pos_r  <= pos_r;
      out_last_r <= ({1'b0, pos_r} == k_r - CFG_W'(1));
      out_err_r  <= 1'b0;
    end else if ((state_r == S_ERR) && out_free) begin
      out_elem_r <= '0;
      out_pos_r  <= '0;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.element      = out_elem_r;
  assign out_ch.position     = out_pos_r;
  assign out_ch.last_of_draw = out_last_r;
  assign out_ch.error        = out_err_r;

`ifndef SYNTHESIS
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error |-> out_ch.last_of_draw)
    else $error("error word without last_of_draw");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("block idle right after accepting a word");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> {1'b0, pos_r} < k_r)
    else $error("position beyond draw length");
  a_emit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_EMIT) |-> $past(state_r == S_DIV))
    else $error("emit step entered without quotient");
`endif

endmodule

FILE: sim/kpu_tb_if.sv
`timescale 1ns / 1ps

// Testbench-side handle bundle: nothing here beyond the block's own interfaces,
// which come from the RTL. This file holds the output word type and the pending stimulus type.
package kpu_tb_pkg;
  import kpu_pkg::*;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic [POS_W-1:0]  position;
    logic              last_of_draw;
    logic              error;
  } draw_word_t;

  // A pending input: either a rank or a register write done while idle.
  typedef struct {
    bit                is_cfg;
    cfg_reg_t          reg_sel;
    logic [CFG_W-1:0]  reg_val;
    logic [RANK_W-1:0] rank;
  } pending_t;
endpackage

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import kpu_pkg::*;
  import kpu_tb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_data;

  kpu_in_if  in_ch  (.clk(clk));
  kpu_out_if out_ch (.clk(clk));

  k_permutation_unrank DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pending_t   pending_q[$];
  draw_word_t expected_words[$];
  logic [CFG_W-1:0] model_pool;
  logic [CFG_W-1:0] model_draw;
  int unsigned mismatches;
  int unsigned words_seen;
  int unsigned ranks_sent;
  int unsigned error_words;
  int unsigned idle_cycles;
  bit          stim_done;
  bit          in_accepted;
  int          burst_left;
  int          gap_left;
  int          stall_phase;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Falling factorial n*(n-1)*...*(n-k+1); fits in 64 bits for n up to 16.
  function automatic longint unsigned falling_fact(int unsigned n, int unsigned k);
    longint unsigned acc;
    acc = 1;
    for (int unsigned i = 0; i < k; i++) acc *= (n - i);
    return acc;
  endfunction

  task automatic predict_draw(input logic [RANK_W-1:0] rank_in);
    longint unsigned rem;
    longint unsigned cnt;
    longint unsigned q;
    int unsigned n;
    int unsigned k;
    int unsigned left;
    logic [3:0] unused[16];
    draw_word_t w;
    n = model_pool;
    k = model_draw;
    rem = rank_in;
    if (k == 0 || k > n || n > MAX_POOL || n > 16) begin
      w = '{element: '0, position: '0, last_of_draw: 1'b1, error: 1'b1};
      expected_words = {expected_words, w};
      return;
    end
    cnt = falling_fact(n, k);
    if (rem >= cnt) begin
      w = '{element: '0, position: '0, last_of_draw: 1'b1, error: 1'b1};
      expected_words = {expected_words, w};
      return;
    end
    for (int unsigned i = 0; i < n; i++) unused[i] = i[3:0];
    left = n;
    for (int unsigned i = 0; i < k; i++) begin
      cnt = cnt / (n - i);
      if (cnt == 0) cnt = 1;
      q = rem / cnt;
      if (q >= left) q = left - 1;
      rem -= q * cnt;
      w.element = unused[q];
      w.position = i[3:0];
      w.last_of_draw = (i + 1 == k);
      w.error = 1'b0;
      expected_words = {expected_words, w};
      for (int unsigned j = q; j + 1 < left; j++) unused[j] = unused[j + 1];
      left--;
    end
  endtask

  function automatic logic [RANK_W-1:0] pick_rank(int unsigned n, int unsigned k);
    longint unsigned lim;
    logic [RANK_W-1:0] r;
    int unsigned sel;
    lim = (k == 0 || k > n) ? 64'd1000 : falling_fact(n, k);
    sel = $urandom_range(0, 19);
    r = {$urandom, $urandom};
    if (sel < 14) r = {$urandom, $urandom} % lim;
    else if (sel == 14) r = lim - 1;
    else if (sel == 15) r = lim;
    else if (sel == 16) r = '0;
    else if (sel == 17) r = '1;
    return r;
  endfunction

  task automatic add_cfg(input int unsigned n, input int unsigned k);
    pending_t p;
    p = '{is_cfg: 1'b1, reg_sel: REG_POOL_SIZE, reg_val: n[CFG_W-1:0], rank: '0};
    pending_q = {pending_q, p};
    p.reg_sel = REG_DRAW_LENGTH;
    p.reg_val = k[CFG_W-1:0];
    pending_q = {pending_q, p};
  endtask

  task automatic add_rank(input logic [RANK_W-1:0] r);
    pending_t p;
    p = '{is_cfg: 1'b0, reg_sel: REG_POOL_SIZE, reg_val: '0, rank: r};
    pending_q = {pending_q, p};
  endtask

  initial begin
    int unsigned n;
    int unsigned k;
    // Directed part: reset setting, extremes, invalid settings and range edges.
    add_rank('0);
    add_rank(45'd1);
    add_rank('1);
    add_cfg(16, 16);
    add_rank('0);
    add_rank(45'd20922789887999);
    add_rank(45'd20922789888000);
    add_rank('1);
    add_rank(45'd12345678901);
    add_cfg(16, 1);
    add_rank(45'd15);
    add_rank(45'd16);
    add_cfg(5, 0);
    add_rank('0);
    add_cfg(4, 5);
    add_rank('0);
    add_cfg(17, 3);
    add_rank(45'd2);
    add_cfg(31, 31);
    add_rank('0);
    add_cfg(0, 0);
    add_rank(45'd7);
    add_cfg(6, 3);
    add_rank(45'd119);
    add_rank(45'd60);
    add_cfg(16, 10);
    add_rank(45'h1555_5555_5555);
    // Random part: a new setting every eight ranks, mostly valid ones.
    for (int unsigned blk = 0; blk < 60; blk++) begin
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(1, 16);
        k = ($urandom_range(0, 3) == 0) ? n : $urandom_range(1, n);
      end else begin
        n = $urandom_range(0, 31);
        k = $urandom_range(0, 31);
      end
      add_cfg(n, k);
      for (int unsigned i = 0; i < 8; i++) add_rank(pick_rank(n, k));
    end
  end

  // Driver: ranks go out in bursts; register writes wait until the block drains.
  always @(negedge clk) begin
    bit cfg_go;
    cfg_go = 1'b0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      if (in_ch.valid && !in_accepted) begin
        // Hold the current word until the block takes it.
      end else if (pending_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        stim_done <= 1'b1;
      end else if (pending_q[0].is_cfg) begin
        in_ch.valid <= 1'b0;
        // The block only takes a rank when idle, so an empty expectation
        // store and a high ready mean nothing is left in flight.
        if (expected_words.size() == 0 && in_ch.ready && !in_ch.valid) begin
          cfg_go = 1'b1;
          cfg_index <= pending_q[0].reg_sel;
          cfg_data <= pending_q[0].reg_val;
          if (pending_q[0].reg_sel == REG_POOL_SIZE) model_pool = pending_q[0].reg_val;
          else model_draw = pending_q[0].reg_val;
          void'(pending_q.pop_front());
        end
      end else if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.ordinal_rank <= pending_q[0].rank;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 6);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      in_accepted = 1'b0;
      cfg_we <= cfg_go;
      stall_phase++;
      out_ch.ready <= ((stall_phase / 40) % 3 == 0) ? 1'b1
                    : ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: predict on each accepted rank, check each accepted word.
  always @(posedge clk) begin
    draw_word_t got;
    draw_word_t want;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_draw(in_ch.ordinal_rank);
        void'(pending_q.pop_front());
        in_accepted = 1'b1;
        ranks_sent++;
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        words_seen++;
        got = '{element: out_ch.element, position: out_ch.position,
                last_of_draw: out_ch.last_of_draw, error: out_ch.error};
        if (got.error) error_words++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: expected %p, got %p (pool %0d draw %0d)",
                       want, got, model_pool, model_draw);
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.ordinal_rank = '0;
    out_ch.ready = 1'b0;
    model_pool = 5'd1;
    model_draw = 5'd1;
    mismatches = 0;
    words_seen = 0;
    ranks_sent = 0;
    error_words = 0;
    idle_cycles = 0;
    stim_done = 1'b0;
    in_accepted = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_phase = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (!(stim_done && expected_words.size() == 0)
           && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", expected_words.size());
      $display("tb_top: FAIL");
      $finish;
    end else begin
      repeat (120) @(posedge clk);
      $display("Sent %0d ranks across many pool/draw settings; checked %0d words",
               ranks_sent, words_seen);
      $display("%0d error words, %0d mismatches, %0d words left over",
               error_words, mismatches, expected_words.size());
      if (mismatches == 0 && expected_words.size() == 0) begin
        $display("tb_top: PASS");
      end else begin
        $display("tb_top: FAIL");
      end
      $finish;
    end
  end
endmodule
